@@ design/nlqt_pkg.sv @@
// ----------------------------------------------------------------------------
// nlqt_pkg
// Shared types and constants for the neighbor link quality table.
// ----------------------------------------------------------------------------
package nlqt_pkg;

    localparam int TABLE_SLOTS = 8;
    localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W       = 7;
    localparam int DVD_W       = 23;
    localparam int DVS_W       = 16;
    localparam int SCORE_W     = 7;

    localparam logic [DVS_W-1:0]   SEND_MAX  = 16'hFFFF;
    localparam logic [SCORE_W-1:0] SCORE_MAX = 7'd100;
    localparam logic [6:0]         PCT_MUL   = 7'd100;
    localparam logic [9:0]         RSSI_OFS  = 10'd100;

    localparam logic [1:0] REG_FRESH_WINDOW = 2'd0;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        OP_HELLO  = 2'd0,
        OP_SEND   = 2'd1,
        OP_EXPIRE = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_UNKNOWN  = 2'd1,
        ST_MAC_BUSY = 2'd2,
        ST_NO_ENTRY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        WR_NONE = 2'd0,
        WR_SAME = 2'd1,
        WR_NEW  = 2'd2,
        WR_SEND = 2'd3
    } wr_kind_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] node;
        logic [47:0] mac;
        logic [7:0]  rssi;
        logic [31:0] now;
        logic        known;
        logic        ok;
        logic [31:0] window;
    } req_t;

    typedef struct packed {
        logic        match_found;
        idx_t        match_idx;
        logic        mac_eq;
        logic        match_stale;
        logic        free_found;
        idx_t        free_idx;
        logic        oldest_found;
        idx_t        oldest_idx;
        logic [31:0] oldest_ls;
        cnt_t        count;
        cnt_t        expired;
    } acc_t;

    typedef struct packed {
        logic     we;
        wr_kind_t kind;
        idx_t     idx;
    } cmd_t;

    typedef struct packed {
        logic [7:0]       avg;
        logic [DVS_W-1:0] sends;
        logic [DVS_W-1:0] fails;
    } view_t;

endpackage

@@ design/nlqt_cell.sv @@
// ----------------------------------------------------------------------------
// nlqt_cell
// One table slot. Evaluates the scan word as it passes and forwards it,
// registered, to the next slot; applies broadcast writes addressed to it.
// ----------------------------------------------------------------------------
module nlqt_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  nlqt_pkg::idx_t   slot_idx,
    input  nlqt_pkg::req_t   req,
    input  logic             tok_in,
    input  nlqt_pkg::acc_t   acc_in,
    input  nlqt_pkg::cmd_t   cmd,
    output logic             tok_out,
    output nlqt_pkg::acc_t   acc_out,
    output nlqt_pkg::view_t  rd
);
    import nlqt_pkg::*;

    logic             valid_reg, valid_next;
    logic [31:0]      last_seen_reg;
    logic [31:0]      node_reg;
    logic [47:0]      mac_reg;
    logic [7:0]       avg_reg;
    logic [DVS_W-1:0] sends_reg;
    logic [DVS_W-1:0] fails_reg;
    logic             tok_reg;
    acc_t             acc_reg, acc_next;

    logic [31:0]      age;
    logic             stale, clr, alive, hit, sel;
    logic signed [9:0] sum3, avg_new;

    assign age   = req.now - last_seen_reg;
    assign stale = age > req.window;
    assign clr   = tok_in && (req.op == OP_EXPIRE) && valid_reg && stale;
    assign alive = valid_reg && !clr;
    assign hit   = alive && (node_reg == req.node);
    assign sel   = cmd.we && (cmd.idx == slot_idx);

    // (3*avg + rssi) / 4, truncated toward zero
    assign sum3 = $signed({{2{avg_reg[7]}}, avg_reg})
                + $signed({{1{avg_reg[7]}}, avg_reg, 1'b0})
                + $signed({{2{req.rssi[7]}}, req.rssi});
    assign avg_new = sum3[9] ? ((sum3 + 10'sd3) >>> 2) : (sum3 >>> 2);

    always_comb
    begin
        acc_next = acc_in;
        if (hit && !acc_in.match_found)
        begin
            acc_next.match_found = 1'b1;
            acc_next.match_idx   = slot_idx;
            acc_next.mac_eq      = (mac_reg == req.mac);
            acc_next.match_stale = stale;
        end
        if (!valid_reg && !acc_in.free_found)
        begin
            acc_next.free_found = 1'b1;
            acc_next.free_idx   = slot_idx;
        end
        if (!acc_in.oldest_found || (last_seen_reg < acc_in.oldest_ls))
        begin
            acc_next.oldest_found = 1'b1;
            acc_next.oldest_idx   = slot_idx;
            acc_next.oldest_ls    = last_seen_reg;
        end
        if (alive)
        begin
            acc_next.count = acc_in.count + cnt_t'(1);
        end
        if (clr)
        begin
            acc_next.expired = acc_in.expired + cnt_t'(1);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (clr)
        begin
            valid_next = 1'b0;
        end
        else if (sel && ((cmd.kind == WR_SAME) || (cmd.kind == WR_NEW)))
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            last_seen_reg <= '0;
            tok_reg       <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_in;
            if (sel && ((cmd.kind == WR_SAME) || (cmd.kind == WR_NEW)))
            begin
                last_seen_reg <= req.now;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_in)
        begin
            acc_reg <= acc_next;
        end
        if (sel)
        begin
            unique case (cmd.kind)
                WR_SAME:
                begin
                    avg_reg  <= avg_new[7:0];
                    node_reg <= req.node;
                    mac_reg  <= req.mac;
                end
                WR_NEW:
                begin
                    avg_reg   <= req.rssi;
                    sends_reg <= '0;
                    fails_reg <= '0;
                    node_reg  <= req.node;
                    mac_reg   <= req.mac;
                end
                WR_SEND:
                begin
                    if (sends_reg != SEND_MAX)
                    begin
                        sends_reg <= sends_reg + DVS_W'(1);
                        if (!req.ok)
                        begin
                            fails_reg <= fails_reg + DVS_W'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign tok_out  = tok_reg;
    assign acc_out  = acc_reg;
    assign rd.avg   = avg_reg;
    assign rd.sends = sends_reg;
    assign rd.fails = fails_reg;

endmodule

@@ design/nlqt_div.sv @@
// ----------------------------------------------------------------------------
// nlqt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nlqt_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [nlqt_pkg::DVD_W-1:0] dividend,
    input  logic [nlqt_pkg::DVS_W-1:0] divisor,
    output logic                       done,
    output logic [nlqt_pkg::DVD_W-1:0] quotient
);
    import nlqt_pkg::*;

    localparam int ITER_W = $clog2(DVD_W + 1);

    logic [ITER_W-1:0] iter_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W:0]    rem_t;
    logic              take;

    assign rem_t = {rem_reg, dvd_reg[DVD_W-1]};
    assign take  = rem_t >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= ITER_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? DVS_W'(rem_t - {1'b0, dvs_reg}) : rem_t[DVS_W-1:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

@@ design/neighbor_link_quality_table_unit.sv @@
// ----------------------------------------------------------------------------
// neighbor_link_quality_table_unit
// Neighbor table with RSSI averaging, send counters, expiry and link score.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_stall) carries one word per operation:
// hello, send outcome, expire tick or score query. Response channel
// (rsp_valid/rsp_stall) returns one word per request: status, link score,
// neighbor count and expired count.
// A request is worked on alone. Its scan word walks the chain of slot cells
// one slot per cycle, then an apply state writes the slot, read and calc
// states read the slot and form the score operands, and a bit-serial divide
// forms the failure percentage. A new request is accepted only once the
// block is back in idle after the divide.
// The finished response moves to an output register, so the next request is
// accepted while that response waits on rsp_stall; a stalled response holds.
// A further finished response waiting behind it holds req_stall high.
// Reset empties the table, sets the fresh window to 30000 ms and drops any
// request in progress. fresh_window_ms is to be written over the APB port at
// address 0 only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module neighbor_link_quality_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  opcode,
    input  logic [31:0] node_id,
    input  logic [47:0] peer_mac,
    input  logic signed [7:0] rssi_dbm,
    input  logic [31:0] now_ms,
    input  logic        node_known,
    input  logic        send_ok,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  status,
    output logic [6:0]  link_score,
    output logic [6:0]  neighbour_count,
    output logic [6:0]  expired_count
);
    import nlqt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_APPLY = 6'b000100,
        S_READ  = 6'b001000,
        S_CALC  = 6'b010000,
        S_DIV   = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [31:0]      window_reg;
    req_t             req_reg;
    logic             start_reg;
    cmd_t             cmd_reg;
    status_t          status_reg, status_next;
    logic             present_reg;
    idx_t             rd_idx_reg;
    cnt_t             count_reg, expired_reg;
    view_t            view_reg;
    logic [6:0]       base_reg;
    logic             out_pend_reg;

    logic             rsp_valid_reg;
    logic [1:0]       status_o_reg;
    logic [6:0]       score_o_reg, count_o_reg, expired_o_reg;

    logic             tok_w [TABLE_SLOTS+1];
    acc_t             acc_w [TABLE_SLOTS+1];
    view_t            rd_w  [TABLE_SLOTS];

    acc_t             fin;
    logic             accept, cfg_wr, bad, conflict, hello_ok;
    idx_t             widx;
    logic             div_start, div_done;
    logic [DVD_W-1:0] quot;
    logic signed [9:0] base_s;
    logic [7:0]       diff;
    logic [6:0]       score;
    logic             load_out;
    logic             tail;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_FRESH_WINDOW);
    assign prdata = (paddr == REG_FRESH_WINDOW) ? window_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= 32'd30000;
        end
        else if (cfg_wr)
        begin
            window_reg <= pwdata;
        end
    end

    // ---------------- slot chain ----------------
    assign tok_w[0] = start_reg;
    assign acc_w[0] = '0;

    for (genvar i = 0; i < TABLE_SLOTS; i++)
    begin : g_cell
        nlqt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .slot_idx (idx_t'(i)),
            .req      (req_reg),
            .tok_in   (tok_w[i]),
            .acc_in   (acc_w[i]),
            .cmd      (cmd_reg),
            .tok_out  (tok_w[i+1]),
            .acc_out  (acc_w[i+1]),
            .rd       (rd_w[i])
        );
    end

    assign fin = acc_w[TABLE_SLOTS];

    // ---------------- decision at chain tail ----------------
    assign bad      = (req_reg.node == 32'd0) || !req_reg.known;
    assign conflict = fin.match_found && !fin.mac_eq && !fin.match_stale;
    assign hello_ok = (req_reg.op == OP_HELLO) && !bad && !conflict;
    assign widx     = fin.match_found ? fin.match_idx :
                      (fin.free_found ? fin.free_idx : fin.oldest_idx);
    assign tail     = (state_reg == S_SCAN) && tok_w[TABLE_SLOTS];

    always_comb
    begin
        unique case (req_reg.op)
            OP_HELLO:  status_next = bad ? ST_UNKNOWN : (conflict ? ST_MAC_BUSY : ST_DONE);
            OP_SEND:   status_next = fin.match_found ? ST_DONE : ST_NO_ENTRY;
            OP_EXPIRE: status_next = ST_DONE;
            OP_QUERY:  status_next = fin.match_found ? ST_DONE : ST_NO_ENTRY;
            default:   status_next = ST_DONE;
        endcase
    end

    // ---------------- sequencing ----------------
    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE) || out_pend_reg;
    assign div_start = (state_reg == S_CALC);
    assign load_out  = out_pend_reg && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_SCAN;
            S_SCAN:  if (tok_w[TABLE_SLOTS]) state_next = S_APPLY;
            S_APPLY: state_next = S_READ;
            S_READ:  state_next = S_CALC;
            S_CALC:  state_next = S_DIV;
            S_DIV:   if (div_done) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            cmd_reg       <= '0;
            out_pend_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= accept;
            if (tail)
            begin
                cmd_reg.we   <= hello_ok || ((req_reg.op == OP_SEND) && fin.match_found);
                cmd_reg.kind <= hello_ok ? ((fin.match_found && fin.mac_eq) ? WR_SAME : WR_NEW)
                                         : WR_SEND;
                cmd_reg.idx  <= hello_ok ? widx : fin.match_idx;
            end
            else
            begin
                cmd_reg.we <= 1'b0;
            end
            if ((state_reg == S_DIV) && div_done)
            begin
                out_pend_reg <= 1'b1;
            end
            else if (load_out)
            begin
                out_pend_reg <= 1'b0;
            end
            if (load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // S_IDLE is not left while a response is pending, so pending drains first
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.op     <= op_t'(opcode);
            req_reg.node   <= node_id;
            req_reg.mac    <= peer_mac;
            req_reg.rssi   <= rssi_dbm;
            req_reg.now    <= now_ms;
            req_reg.known  <= node_known;
            req_reg.ok     <= send_ok;
            req_reg.window <= window_reg;
        end
        if (tail)
        begin
            status_reg  <= status_next;
            present_reg <= hello_ok || fin.match_found;
            rd_idx_reg  <= hello_ok ? widx : fin.match_idx;
            count_reg   <= fin.count
                         + cnt_t'(hello_ok && !fin.match_found && fin.free_found);
            expired_reg <= fin.expired;
        end
        if (state_reg == S_READ)
        begin
            view_reg <= rd_w[rd_idx_reg];
        end
        if (state_reg == S_CALC)
        begin
            if (base_s[9])
            begin
                base_reg <= 7'd0;
            end
            else if (base_s > $signed({3'b000, SCORE_MAX}))
            begin
                base_reg <= SCORE_MAX;
            end
            else
            begin
                base_reg <= base_s[6:0];
            end
        end
        if (load_out)
        begin
            status_o_reg  <= status_reg;
            score_o_reg   <= score;
            count_o_reg   <= count_reg;
            expired_o_reg <= expired_reg;
        end
    end

    // ---------------- score ----------------
    assign base_s = ($signed({{2{view_reg.avg[7]}}, view_reg.avg}) + $signed(RSSI_OFS)) <<< 1;

    nlqt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (DVD_W'(view_reg.fails) * DVD_W'(PCT_MUL)),
        .divisor  (view_reg.sends),
        .done     (div_done),
        .quotient (quot)
    );

    logic [7:0] result_reg;
    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            result_reg <= (view_reg.sends != '0) ? {1'b0, quot[7:1]} : 8'd0;
        end
    end

    assign diff  = {1'b0, base_reg} - result_reg;
    assign score = (!present_reg || diff[7]) ? 7'd0 : diff[6:0];

    assign rsp_valid       = rsp_valid_reg;
    assign status          = status_o_reg;
    assign link_score      = score_o_reg;
    assign neighbour_count = count_o_reg;
    assign expired_count   = expired_o_reg;

    // ---------------- checks ----------------
    a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (link_score <= SCORE_MAX))
        else $error("link score above maximum");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (neighbour_count <= CNT_W'(TABLE_SLOTS)))
        else $error("neighbor count above table size");

    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tok_w[TABLE_SLOTS] |-> (state_reg == S_SCAN))
        else $error("scan word left chain outside scan");

    a_expire_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (expired_count != 7'd0)) |-> (status == ST_DONE))
        else $error("expired entries reported with error status");

endmodule
